// File: design/qemcc_pkg.sv
// Shared types and constants for the quadrature encoder CC bank.
`default_nettype none
package qemcc_pkg;

	// request kinds carried on s_tuser
	localparam logic [1:0] REQ_PIN  = 2'd0;
	localparam logic [1:0] REQ_CC   = 2'd1;
	localparam logic [1:0] REQ_SET  = 2'd2;
	localparam logic [1:0] REQ_READ = 2'd3;

	localparam int PIN_W     = 4;
	localparam int SETUP_W   = 20;
	localparam int CFG_IDX_W = 2;
	localparam int IN_DATA_W = 48;
	localparam int OUT_DATA_W = 32;
	localparam int VALUE_W   = 7;
	localparam int CC_BASE   = 11;
	localparam logic [VALUE_W-1:0] VALUE_MAX = 7'd127;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic step;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_scan;
		logic scan_last;
	} dp_status_t;

endpackage
`default_nettype wire

// File: design/quad_encoder_midi_cc_bank.sv
// Top level of the quadrature encoder bank with MIDI CC reporting.
// CC and set words are taken without a scan, so s_tready stays high after them. A word that
//   causes results moves the controller to ST_SCAN, and each result is registered before it
//   shows on m_tvalid. s_tready stays low through the scan of a pin sample or read, which walks
//   the encoders up to the highest changed one or the read target, waiting on m_tready.
// Reset (arst_n low, asynchronous): knob values and A history clear, setup returns to
//   cc 11 + k with listen off, the first pin sample only captures the A levels.
`default_nettype none
module quad_encoder_midi_cc_bank #(
	parameter int NUM_ENCODERS = 4,
	parameter int STEP_SIZE    = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request word
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// pins_a[3:0], pins_b[7:4], msg_is_output[8], msg_port[16:9], msg_channel[21:17],
	// msg_cc[28:22], msg_value[35:29], target_encoder[37:36], set_value[46:38], zero pad
	input  wire logic [47:0] s_tdata,
	// req_type[1:0]
	input  wire logic [1:0]  s_tuser,
	// result word
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// source_encoder[1:0], out_port[9:2], out_channel[14:10], out_cc[21:15],
	// out_value[28:22], zero pad
	output logic [31:0]      m_tdata,
	// is_last
	output logic             m_tlast,
	// setup register writes
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [19:0] cfg_wdata
);

	qemcc_pkg::dp_cmd_t    cmd;
	qemcc_pkg::dp_status_t status;

	// controller: holds ready in idle and advances the scan one encoder per cycle unless a result waits on m_tready
	qemcc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath: state, saturating step, match logic and the output register
	qemcc_datapath #(
		.NUM_ENCODERS (NUM_ENCODERS),
		.STEP_SIZE    (STEP_SIZE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.status    (status)
	);

endmodule
`default_nettype wire

// File: design/qemcc_ctrl.sv
// Controller state machine: accepts words and sequences the encoder scan.
`default_nettype none
module qemcc_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire qemcc_pkg::dp_status_t status,
	output qemcc_pkg::dp_cmd_t         cmd
);

	qemcc_pkg::state_t state_q;
	qemcc_pkg::state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qemcc_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			qemcc_pkg::ST_IDLE: begin
				if (s_tvalid && status.need_scan) begin
					state_next = qemcc_pkg::ST_SCAN;
				end
			end
			qemcc_pkg::ST_SCAN: begin
				if (status.scan_last) begin
					state_next = qemcc_pkg::ST_IDLE;
				end
			end
			default: state_next = qemcc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready   = 1'b0;
		cmd.accept = 1'b0;
		cmd.step   = 1'b0;
		unique case (state_q)
			qemcc_pkg::ST_IDLE: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
			end
			qemcc_pkg::ST_SCAN: begin
				cmd.step = 1'b1;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: design/qemcc_datapath.sv
// Datapath: setup registers, knob values, scan mask and the output register.
`default_nettype none
module qemcc_datapath #(
	parameter int NUM_ENCODERS = 4,
	parameter int STEP_SIZE    = 4
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic [qemcc_pkg::IN_DATA_W-1:0]      s_tdata,
	input  wire logic [1:0]                           s_tuser,
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	output logic [qemcc_pkg::OUT_DATA_W-1:0]          m_tdata,
	output logic                                      m_tlast,
	input  wire logic                                 cfg_we,
	input  wire logic [qemcc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [qemcc_pkg::SETUP_W-1:0]        cfg_wdata,
	input  wire qemcc_pkg::dp_cmd_t                   cmd,
	output qemcc_pkg::dp_status_t                     status
);

	localparam int IW    = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;
	localparam int EXT_W = (NUM_ENCODERS > qemcc_pkg::PIN_W) ? NUM_ENCODERS
		: qemcc_pkg::PIN_W;
	localparam logic [7:0] STEP8 = 8'(STEP_SIZE);
	localparam logic [3:0] NUM4  = 4'(NUM_ENCODERS);

	// input word fields
	logic [qemcc_pkg::PIN_W-1:0] pins_a;
	logic [qemcc_pkg::PIN_W-1:0] pins_b;
	logic                        msg_is_output;
	logic [7:0]                  msg_port;
	logic [4:0]                  msg_channel;
	logic [6:0]                  msg_cc;
	logic [6:0]                  msg_value;
	logic [1:0]                  target_encoder;
	logic signed [8:0]           set_value;

	assign pins_a         = s_tdata[3:0];
	assign pins_b         = s_tdata[7:4];
	assign msg_is_output  = s_tdata[8];
	assign msg_port       = s_tdata[16:9];
	assign msg_channel    = s_tdata[21:17];
	assign msg_cc         = s_tdata[28:22];
	assign msg_value      = s_tdata[35:29];
	assign target_encoder = s_tdata[37:36];
	assign set_value      = s_tdata[46:38];

	logic [qemcc_pkg::SETUP_W-1:0] setup_q [NUM_ENCODERS];
	logic [qemcc_pkg::VALUE_W-1:0] knob_q  [NUM_ENCODERS];
	logic [NUM_ENCODERS-1:0]       last_a_q;
	logic                          primed_q;
	logic [NUM_ENCODERS-1:0]       mask_q;
	logic [NUM_ENCODERS-1:0]       dir_up_q;
	logic                          mode_pin_q;
	logic [IW-1:0]                 idx_q;

	logic                          out_valid_q;
	logic [1:0]                    out_src_q;
	logic [7:0]                    out_port_q;
	logic [4:0]                    out_channel_q;
	logic [6:0]                    out_cc_q;
	logic [6:0]                    out_value_q;
	logic                          out_last_q;

	logic [EXT_W-1:0]              a_ext;
	logic [EXT_W-1:0]              b_ext;
	logic [NUM_ENCODERS-1:0]       a_vec;
	logic [NUM_ENCODERS-1:0]       b_vec;
	logic [NUM_ENCODERS-1:0]       changed;
	logic [IW-1:0]                 tgt;
	logic [NUM_ENCODERS-1:0]       tgt_bit;
	logic [NUM_ENCODERS-1:0]       idx_bit;
	logic [NUM_ENCODERS-1:0]       mask_rest;
	logic [6:0]                    set_clamped;
	logic [NUM_ENCODERS-1:0]       cc_hit;

	logic [6:0]                    cur_value;
	logic [7:0]                    up_sum;
	logic [6:0]                    up_value;
	logic [6:0]                    down_value;
	logic [6:0]                    new_value;
	logic                          slot_free;
	logic                          advance;
	logic                          emit;
	logic [qemcc_pkg::SETUP_W-1:0] cur_setup;

	// encoders beyond the pin vector see both pins low
	assign a_ext   = EXT_W'(pins_a);
	assign b_ext   = EXT_W'(pins_b);
	assign a_vec   = a_ext[NUM_ENCODERS-1:0];
	assign b_vec   = b_ext[NUM_ENCODERS-1:0];
	assign changed = a_vec ^ last_a_q;

	// target modulo the encoder count by repeated compare and subtract
	always_comb begin
		logic [3:0] t;
		t = {2'b00, target_encoder};
		for (int i = 0; i < 3; i++) begin
			if (t >= NUM4) begin
				t = t - NUM4;
			end
		end
		tgt = IW'(t);
	end

	assign tgt_bit = NUM_ENCODERS'(1) << tgt;
	assign idx_bit = NUM_ENCODERS'(1) << idx_q;

	always_comb begin
		if (set_value[8]) begin
			set_clamped = 7'd0;
		end else if (set_value[7]) begin
			set_clamped = qemcc_pkg::VALUE_MAX;
		end else begin
			set_clamped = set_value[6:0];
		end
	end

	always_comb begin
		for (int k = 0; k < NUM_ENCODERS; k++) begin
			cc_hit[k] = setup_q[k][19] && (setup_q[k][7:0] == msg_port)
				&& (({1'b0, setup_q[k][11:8]} + 5'd1) == msg_channel)
				&& (setup_q[k][18:12] == msg_cc);
		end
	end

	// saturating step of the encoder under the scan pointer
	assign cur_value  = knob_q[idx_q];
	assign cur_setup  = setup_q[idx_q];
	assign up_sum     = {1'b0, cur_value} + STEP8;
	assign up_value   = (up_sum > {1'b0, qemcc_pkg::VALUE_MAX}) ? qemcc_pkg::VALUE_MAX
		: up_sum[6:0];
	assign down_value = ({1'b0, cur_value} < STEP8) ? 7'd0
		: 7'({1'b0, cur_value} - STEP8);
	assign new_value  = !mode_pin_q ? cur_value
		: (dir_up_q[idx_q] ? up_value : down_value);

	assign slot_free = !out_valid_q || m_tready;
	assign advance   = cmd.step && (!mask_q[idx_q] || slot_free);
	assign emit      = cmd.step && mask_q[idx_q] && slot_free;
	assign mask_rest = mask_q & ~idx_bit;

	assign status.need_scan = (s_tuser == qemcc_pkg::REQ_READ)
		|| ((s_tuser == qemcc_pkg::REQ_PIN) && primed_q && (changed != '0));
	assign status.scan_last = advance && (mask_rest == '0);

	// setup registers, knob values and pin history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_ENCODERS; k++) begin
				setup_q[k] <= qemcc_pkg::SETUP_W'(((qemcc_pkg::CC_BASE + k) & 127) << 12);
				knob_q[k]  <= '0;
			end
			last_a_q <= '0;
			primed_q <= 1'b0;
		end else begin
			if (cfg_we && ({2'b00, cfg_index} < 4'(NUM_ENCODERS))) begin
				setup_q[IW'(cfg_index)] <= cfg_wdata;
			end
			if (cmd.accept) begin
				case (s_tuser)
					qemcc_pkg::REQ_PIN: begin
						last_a_q <= a_vec;
						primed_q <= 1'b1;
					end
					qemcc_pkg::REQ_CC: begin
						if (!msg_is_output) begin
							for (int k = 0; k < NUM_ENCODERS; k++) begin
								if (cc_hit[k]) begin
									knob_q[k] <= msg_value;
								end
							end
						end
					end
					qemcc_pkg::REQ_SET: begin
						knob_q[tgt] <= set_clamped;
					end
					default: begin
					end
				endcase
			end
			if (emit) begin
				knob_q[idx_q] <= new_value;
			end
		end
	end

	// scan sequencer registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			if (s_tuser == qemcc_pkg::REQ_READ) begin
				mask_q     <= tgt_bit;
				idx_q      <= tgt;
				mode_pin_q <= 1'b0;
			end else begin
				mask_q     <= changed;
				idx_q      <= '0;
				mode_pin_q <= 1'b1;
			end
			dir_up_q <= ~(a_vec ^ b_vec);
		end else if (advance) begin
			mask_q <= mask_rest;
			idx_q  <= idx_q + IW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_src_q     <= 2'(idx_q);
			out_port_q    <= cur_setup[7:0];
			out_channel_q <= {1'b0, cur_setup[11:8]} + 5'd1;
			out_cc_q      <= cur_setup[18:12];
			out_value_q   <= new_value;
			out_last_q    <= (mask_rest == '0);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {3'b000, out_value_q, out_cc_q, out_channel_q, out_port_q, out_src_q};

endmodule
`default_nettype wire

// File: design/qemcc_checker.sv
// Port-level checker for the encoder bank, bound to the top level.
`default_nettype none
module qemcc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [1:0]  s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic        m_tlast
);

	// hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result word dropped or changed while stalled");

	// reported channel is one-based
	a_chan_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[14:10] != 5'd0)
		else $error("result carries channel zero");

	// pad bits stay clear
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[31:29] == 3'd0)
		else $error("result pad bits set");

	// CC and set words leave the block ready for the next word
	a_quick_words: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready
		&& (s_tuser == qemcc_pkg::REQ_CC || s_tuser == qemcc_pkg::REQ_SET)
		|=> s_tready)
		else $error("CC or set word held the block busy");

endmodule

bind quad_encoder_midi_cc_bank qemcc_checker u_qemcc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
`default_nettype wire
